// File: rtl/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned DT_W     = 24;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CFG_W    = 24;

  typedef enum logic [1:0] {
    REG_GAIN_PROP     = 2'd0,
    REG_GAIN_INTEG    = 2'd1,
    REG_GAIN_DERIV    = 2'd2,
    REG_TARGET_OFFSET = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0]   gain_prop;
    logic signed [GAIN_W-1:0]   gain_integ;
    logic signed [GAIN_W-1:0]   gain_deriv;
    logic signed [OFFSET_W-1:0] target_offset;
  } cfg_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_INTEG  = 9'b000000010,
    ST_MUL_P  = 9'b000000100,
    ST_MUL_I  = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_MUL_D  = 9'b000100000,
    ST_SUM_PI = 9'b001000000,
    ST_SUM_D  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

// File: rtl/dpc_regs.sv
`default_nettype none

module dpc_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire dpc_pkg::reg_idx_e cfg_index_i,
  input  wire logic [dpc_pkg::CFG_W-1:0] cfg_data_i,
  output dpc_pkg::cfg_t          cfg_o
);
  import dpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN_PROP:     cfg_d.gain_prop     = cfg_data_i[GAIN_W-1:0];
        REG_GAIN_INTEG:    cfg_d.gain_integ    = cfg_data_i[GAIN_W-1:0];
        REG_GAIN_DERIV:    cfg_d.gain_deriv    = cfg_data_i[GAIN_W-1:0];
        REG_TARGET_OFFSET: cfg_d.target_offset = cfg_data_i[OFFSET_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dpc_arith.sv
`default_nettype none

// Shared shift-add multiplier and restoring divider around one adder.
// Multiply: signed gain (a) times signed operand (b), one gain bit per cycle, MSB first.
// Divide: unsigned DV-bit dividend (b) by 24-bit divisor (a), one quotient bit per cycle.
module dpc_arith #(
  parameter int unsigned XW = 40,
  parameter int unsigned DV = 35
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dpc_pkg::arith_req_t         req_i,
  input  wire logic [dpc_pkg::GAIN_W-1:0]  a_i,
  input  wire logic [XW-1:0]               b_i,
  output logic                             done_o,
  output logic [dpc_pkg::GAIN_W+XW-1:0]    res_o
);
  import dpc_pkg::*;

  localparam int unsigned PW   = GAIN_W + XW;
  localparam int unsigned NMAX = (DV > GAIN_W) ? DV : GAIN_W;
  localparam int unsigned CNTW = $clog2(NMAX);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            first_q, first_d;
  arith_op_e       op_q, op_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [PW-1:0]   acc_q, acc_d;
  logic [GAIN_W-1:0] a_q, a_d;
  logic [XW-1:0]   x_q, x_d;

  logic [PW-1:0]   add_a, add_b, sum;
  logic            add_sub;
  logic            qbit;

  // single adder shared by both operations
  always_comb begin
    case (op_q)
      OP_MUL: begin
        add_a   = {acc_q[PW-2:0], 1'b0};
        add_b   = a_q[GAIN_W-1] ? PW'($signed(x_q)) : '0;
        add_sub = first_q;
      end
      OP_DIV: begin
        add_a   = {acc_q[PW-2:0], x_q[DV-1]};
        add_b   = PW'(a_q);
        add_sub = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
    sum  = add_a + (add_sub ? ~add_b : add_b) + PW'(add_sub);
    qbit = ~sum[PW-1];
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    first_d = first_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    a_d     = a_q;
    x_d     = x_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d  = 1'b1;
        op_d    = req_i.op;
        first_d = 1'b1;
        acc_d   = '0;
        a_d     = a_i;
        x_d     = b_i;
        cnt_d   = (req_i.op == OP_DIV) ? CNTW'(DV - 1) : CNTW'(GAIN_W - 1);
      end
    end else begin
      first_d = 1'b0;
      case (op_q)
        OP_MUL: begin
          acc_d = sum;
          a_d   = {a_q[GAIN_W-2:0], 1'b0};
        end
        OP_DIV: begin
          // keep the trial remainder only when it did not go negative
          acc_d = qbit ? sum : add_a;
          x_d   = {x_q[XW-2:0], qbit};
        end
        default: acc_d = acc_q;
      endcase
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      op_q    <= OP_MUL;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      first_q <= first_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    x_q   <= x_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_DIV) ? PW'(x_q[DV-1:0]) : acc_q;

endmodule

`default_nettype wire

// File: rtl/differential_pid_controller_top.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  left_distance_i, right_distance_i, elapsed_us_i
// result    out        out_valid_o / out_stall_i turn_value_o, sat_flag_o, zero_interval_flag_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item's divide yields DV = EW + 17 quotient bits, and the next item is taken only
// once the controller has returned to idle after handing its result to the output register.
// Three 24-step multiplies and the DV-step divide all run on the one shared adder in
// dpc_arith. A zero interval skips the divide and the derivative multiply.
// Reset clears the integral, the previous error, the gains and the offset.
// A finished result waits in the output register; the next item is taken meanwhile and
// held in its last state until that register is free.
module differential_pid_controller_top #(
  parameter int unsigned DIST_BITS = 16,
  parameter int unsigned ACC_BITS  = 40
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [DIST_BITS-1:0]          left_distance_i,
  input  wire logic [DIST_BITS-1:0]          right_distance_i,
  input  wire logic [dpc_pkg::DT_W-1:0]      elapsed_us_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [dpc_pkg::OUT_W-1:0]   turn_value_o,
  output logic                               sat_flag_o,
  output logic                               zero_interval_flag_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire dpc_pkg::reg_idx_e             cfg_index_i,
  input  wire logic [dpc_pkg::CFG_W-1:0]     cfg_data_i
);
  import dpc_pkg::*;

  localparam int unsigned ERR_BITS = DIST_BITS + 2;
  localparam int unsigned EW = (DIST_BITS + 2 > OFFSET_W + 1) ? DIST_BITS + 2 : OFFSET_W + 1;
  localparam int unsigned DV = EW + 1 + FRAC_W;
  localparam int unsigned XW = (ACC_BITS > DV) ? ACC_BITS : DV;
  localparam int unsigned PW = GAIN_W + XW;
  localparam int unsigned LW = ((PW > 64) ? PW : 64) + 1;
  localparam int unsigned SW = ((ACC_BITS > EW) ? ACC_BITS : EW) + 1;

  localparam logic signed [LW-1:0] MAX64 = LW'($signed({1'b0, {63{1'b1}}}));
  localparam logic signed [LW-1:0] MIN64 = ~MAX64;
  localparam logic signed [63:0]   MAX48 = 64'($signed({1'b0, {(OUT_W-1){1'b1}}}));
  localparam logic signed [63:0]   MIN48 = ~MAX48;
  localparam logic signed [SW-1:0] MAXACC = SW'($signed({1'b0, {(ACC_BITS-1){1'b1}}}));
  localparam logic signed [SW-1:0] MINACC = ~MAXACC;

  // clamp to 64-bit signed; top bit of the result is the saturation flag
  function automatic logic [64:0] sat64(input logic signed [LW-1:0] v);
    if (v > MAX64) begin
      sat64 = {1'b1, MAX64[63:0]};
    end else if (v < MIN64) begin
      sat64 = {1'b1, MIN64[63:0]};
    end else begin
      sat64 = {1'b0, v[63:0]};
    end
  endfunction

  cfg_t       cfg;
  arith_req_t req;
  logic [GAIN_W-1:0] arith_a;
  logic [XW-1:0]     arith_b;
  logic              arith_done;
  logic [PW-1:0]     arith_res;

  state_e state_q, state_d;
  logic   launched_q, launched_d;

  logic signed [EW-1:0]       err_q, err_d;
  logic [DT_W-1:0]            dt_q, dt_d;
  logic                       zero_iv_q, zero_iv_d;
  logic signed [EW:0]         diff_q, diff_d;
  logic signed [ACC_BITS-1:0] error_sum_q, error_sum_d;
  logic signed [ERR_BITS-1:0] last_error_q, last_error_d;
  logic signed [DV-1:0]       deriv_q, deriv_d;
  logic signed [63:0]         p_q, p_d, i_q, i_d, d_q, d_d, total_q, total_d;
  logic                       sat_q, sat_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]    turn_q, turn_d;
  logic                       out_sat_q, out_sat_d;
  logic                       out_zero_q, out_zero_d;

  logic signed [EW-1:0]   err_in;
  logic signed [SW-1:0]   int_sum;
  logic [EW:0]            diff_mag;
  logic [DV-1:0]          dividend;
  logic [DV-1:0]          quot;
  logic [64:0]            prod_sat;
  logic [64:0]            add_sat;
  logic signed [63:0]     prod_val;

  dpc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dpc_arith #(
    .XW (XW),
    .DV (DV)
  ) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (arith_a),
    .b_i    (arith_b),
    .done_o (arith_done),
    .res_o  (arith_res)
  );

  always_comb begin
    err_in = EW'($signed({1'b0, right_distance_i})) - EW'($signed({1'b0, left_distance_i}))
             - EW'(cfg.target_offset);
    int_sum  = SW'(error_sum_q) + SW'(err_q);
    diff_mag = diff_q[EW] ? (~diff_q + 1'b1) : diff_q;
    dividend = {diff_mag, {FRAC_W{1'b0}}};
    quot     = arith_res[DV-1:0];
    prod_sat = sat64(LW'($signed(arith_res)));
    prod_val = $signed(prod_sat[63:0]);
    case (state_q)
      ST_SUM_PI: add_sat = sat64(LW'(p_q) + LW'(i_q));
      ST_SUM_D:  add_sat = sat64(LW'(total_q) + LW'(d_q));
      default:   add_sat = '0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    launched_d   = launched_q;
    err_d        = err_q;
    dt_d         = dt_q;
    zero_iv_d    = zero_iv_q;
    diff_d       = diff_q;
    error_sum_d  = error_sum_q;
    last_error_d = last_error_q;
    deriv_d      = deriv_q;
    p_d          = p_q;
    i_d          = i_q;
    d_d          = d_q;
    total_d      = total_q;
    sat_d        = sat_q;
    out_valid_d  = out_valid_q & out_stall_i;
    turn_d       = turn_q;
    out_sat_d    = out_sat_q;
    out_zero_d   = out_zero_q;
    req.start    = 1'b0;
    req.op       = OP_MUL;
    arith_a      = cfg.gain_prop;
    arith_b      = XW'(err_q);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          err_d     = err_in;
          dt_d      = elapsed_us_i;
          zero_iv_d = (elapsed_us_i == '0);
          sat_d     = 1'b0;
          state_d   = ST_INTEG;
        end
      end
      ST_INTEG: begin
        if (int_sum > MAXACC) begin
          error_sum_d = MAXACC[ACC_BITS-1:0];
          sat_d       = 1'b1;
        end else if (int_sum < MINACC) begin
          error_sum_d = MINACC[ACC_BITS-1:0];
          sat_d       = 1'b1;
        end else begin
          error_sum_d = int_sum[ACC_BITS-1:0];
        end
        diff_d       = (EW+1)'(err_q) - (EW+1)'(last_error_q);
        last_error_d = ERR_BITS'(err_q);
        state_d      = ST_MUL_P;
      end
      ST_MUL_P: begin
        arith_a = cfg.gain_prop;
        arith_b = XW'(err_q);
        if (!launched_q) begin
          req.start  = 1'b1;
          launched_d = 1'b1;
        end else if (arith_done) begin
          p_d        = prod_val;
          sat_d      = sat_q | prod_sat[64];
          launched_d = 1'b0;
          state_d    = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        arith_a = cfg.gain_integ;
        arith_b = XW'(error_sum_q);
        if (!launched_q) begin
          req.start  = 1'b1;
          launched_d = 1'b1;
        end else if (arith_done) begin
          i_d        = prod_val;
          sat_d      = sat_q | prod_sat[64];
          launched_d = 1'b0;
          // zero interval: derivative term is zero, skip divide and multiply
          if (zero_iv_q) begin
            d_d     = '0;
            state_d = ST_SUM_PI;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        req.op  = OP_DIV;
        arith_a = dt_q;
        arith_b = XW'(dividend);
        if (!launched_q) begin
          req.start  = 1'b1;
          launched_d = 1'b1;
        end else if (arith_done) begin
          deriv_d    = diff_q[EW] ? $signed(~quot + 1'b1) : $signed(quot);
          launched_d = 1'b0;
          state_d    = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        arith_a = cfg.gain_deriv;
        arith_b = XW'(deriv_q);
        if (!launched_q) begin
          req.start  = 1'b1;
          launched_d = 1'b1;
        end else if (arith_done) begin
          d_d        = prod_val >>> FRAC_W;
          sat_d      = sat_q | prod_sat[64];
          launched_d = 1'b0;
          state_d    = ST_SUM_PI;
        end
      end
      ST_SUM_PI: begin
        total_d = $signed(add_sat[63:0]);
        sat_d   = sat_q | add_sat[64];
        state_d = ST_SUM_D;
      end
      ST_SUM_D: begin
        total_d = $signed(add_sat[63:0]);
        sat_d   = sat_q | add_sat[64];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_zero_d  = zero_iv_q;
          if (total_q > MAX48) begin
            turn_d    = MAX48[OUT_W-1:0];
            out_sat_d = 1'b1;
          end else if (total_q < MIN48) begin
            turn_d    = MIN48[OUT_W-1:0];
            out_sat_d = 1'b1;
          end else begin
            turn_d    = total_q[OUT_W-1:0];
            out_sat_d = sat_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d    = ST_IDLE;
        launched_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      launched_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else begin
      state_q      <= state_d;
      launched_q   <= launched_d;
      out_valid_q  <= out_valid_d;
      error_sum_q  <= error_sum_d;
      last_error_q <= last_error_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    dt_q       <= dt_d;
    zero_iv_q  <= zero_iv_d;
    diff_q     <= diff_d;
    deriv_q    <= deriv_d;
    p_q        <= p_d;
    i_q        <= i_d;
    d_q        <= d_d;
    total_q    <= total_d;
    sat_q      <= sat_d;
    turn_q     <= turn_d;
    out_sat_q  <= out_sat_d;
    out_zero_q <= out_zero_d;
  end

  assign in_stall_o           = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign turn_value_o         = turn_q;
  assign sat_flag_o           = out_sat_q;
  assign zero_interval_flag_o = out_zero_q;

endmodule

`default_nettype wire
